/* sv/bmc_pkg.sv */
// Shared types, constants and helper functions for the binary-mask 3x3 stream block.
// Used by the interfaces, every module of the block and the checker.
package bmc_pkg;

  localparam int PIX_W          = 8;
  localparam int COORD_W        = 10;
  localparam int DIM_W          = 11;
  localparam int MASK_W         = 9;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 11;
  localparam int LINE_W         = 2 * PIX_W;
  localparam int WIN_ROWS       = 3;
  localparam int QUEUE_DEPTH    = 3;
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int DIM_RESET      = 1024;
  localparam int DIM_MIN        = 3;

  localparam logic [MASK_W-1:0] MASK_RESET = 9'h1FF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_KERNEL_MASK  = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [COORD_W-1:0] out_row;
    logic [COORD_W-1:0] out_col;
    logic [PIX_W-1:0]   value;
    logic               frame_end;
  } res_t;

  // Last valid coordinate for a frame dimension once clamped to [DIM_MIN, maxv].
  function automatic int unsigned dim_last(input logic [DIM_W-1:0] v, input int unsigned maxv);
    int unsigned vi;
    vi = 32'(v);
    if (vi < 32'(DIM_MIN)) begin
      return 32'(DIM_MIN) - 32'd1;
    end else if (vi > maxv) begin
      return maxv - 32'd1;
    end
    return vi - 32'd1;
  endfunction

endpackage

/* sv/bmc_if.sv */
// Valid/ready stream interfaces for the pixel input and the result output.
// Depends on bmc_pkg for field widths.
interface bmc_pix_if;
  logic                      valid;
  logic                      ready;
  logic [bmc_pkg::PIX_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface bmc_res_if;
  logic                        valid;
  logic                        ready;
  logic [bmc_pkg::COORD_W-1:0] out_row;
  logic [bmc_pkg::COORD_W-1:0] out_col;
  logic [bmc_pkg::PIX_W-1:0]   value;
  logic                        frame_end;

  modport source (output valid, output out_row, output out_col, output value,
                  output frame_end, input ready);
  modport sink   (input valid, input out_row, input out_col, input value,
                  input frame_end, output ready);
endinterface

/* sv/bmc_line_store.sv */
// Line store memory: one word per column holding the two previous rows.
// Synchronous read with registered data, one write port. Depends on bmc_pkg.
module bmc_line_store #(
  parameter int DEPTH = bmc_pkg::MAX_WIDTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  logic                       rd_en,
  input  logic [AW-1:0]              rd_addr,
  output logic [bmc_pkg::LINE_W-1:0] rd_data,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic [bmc_pkg::LINE_W-1:0] wr_data
);

  logic [bmc_pkg::LINE_W-1:0] mem [DEPTH];
  logic [bmc_pkg::LINE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* sv/bmc_window.sv */
// 3x3 window: two stored columns plus the column arriving from the line store.
// Forms the masked neighbourhood sum modulo 256. Depends on bmc_pkg.
module bmc_window (
  input  logic                                             clk,
  input  logic                                             rst_n,
  input  logic                                             step,
  input  logic [bmc_pkg::WIN_ROWS-1:0][bmc_pkg::PIX_W-1:0] cur,
  input  logic [bmc_pkg::MASK_W-1:0]                       mask,
  output logic [bmc_pkg::PIX_W-1:0]                        sum
);

  // Entries 0..2 are the oldest column, 3..5 the middle one, row 0 first.
  logic [2*bmc_pkg::WIN_ROWS-1:0][bmc_pkg::PIX_W-1:0] win_r;
  logic [2*bmc_pkg::WIN_ROWS-1:0][bmc_pkg::PIX_W-1:0] win_nxt;
  logic [bmc_pkg::WIN_ROWS-1:0][bmc_pkg::PIX_W-1:0]   grp;

  always_comb begin
    for (int t = 0; t < bmc_pkg::WIN_ROWS; t++) begin
      grp[t] = (mask[3*t]   ? win_r[t]                    : '0)
             + (mask[3*t+1] ? win_r[bmc_pkg::WIN_ROWS+t] : '0)
             + (mask[3*t+2] ? cur[t]                      : '0);
    end
    sum = grp[0] + grp[1] + grp[2];
  end

  always_comb begin
    win_nxt = win_r;
    if (step) begin
      for (int t = 0; t < bmc_pkg::WIN_ROWS; t++) begin
        win_nxt[t]                    = win_r[bmc_pkg::WIN_ROWS+t];
        win_nxt[bmc_pkg::WIN_ROWS+t] = cur[t];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else begin
      win_r <= win_nxt;
    end
  end

endmodule

/* sv/bmc_out_queue.sv */
// Three-word result queue between the window stage and the output channel.
// Its fill count lets the input side keep accepting while results wait. Depends on bmc_pkg.
module bmc_out_queue (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          push,
  input  bmc_pkg::res_t                                 push_data,
  output logic                                          pop_valid,
  input  logic                                          pop_ready,
  output bmc_pkg::res_t                                 pop_data,
  output logic [$clog2(bmc_pkg::QUEUE_DEPTH+1)-1:0]     count
);

  localparam int PW = $clog2(bmc_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(bmc_pkg::QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(bmc_pkg::QUEUE_DEPTH - 1);

  bmc_pkg::res_t   buf_r [bmc_pkg::QUEUE_DEPTH];
  logic [PW-1:0]   head_r, head_nxt;
  logic [PW-1:0]   tail_r, tail_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            pop;

  assign pop_valid = (count_r != '0);
  assign pop_data  = buf_r[head_r];
  assign pop       = pop_valid && pop_ready;
  assign count     = count_r;

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (pop) begin
      head_nxt = (head_r == LAST) ? '0 : head_r + 1'b1;
    end
    if (push) begin
      tail_nxt = (tail_r == LAST) ? '0 : tail_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[tail_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

/* sv/binary_mask_conv3x3_stream.sv */
// Top level of the streaming 3x3 binary-mask neighbourhood sum.
// Depends on bmc_pkg, bmc_if, bmc_line_store, bmc_window and bmc_out_queue.
//
//   port     | dir | handshake        | word
//   in_pix   | in  | valid / ready    | pixel
//   out_res  | out | valid / ready    | out_row, out_col, value, frame_end
//   cfg_*    | in  | cfg_we (no wait) | cfg_index selects register, cfg_wdata
//
// One pixel is taken per clock while in_pix.ready is high; its result (interior pixels
// only) passes the second-stage registers and the result queue before it is offered.
// The line store is read when a pixel is accepted and written back the cycle after,
// so one memory access pair per word.
// Reset clears the counters, window and queue; the line store needs no clearing pass.
// A three-word result queue absorbs output stalls; in_pix.ready falls once
// the queue plus the word in flight would fill it.
module binary_mask_conv3x3_stream #(
  parameter int MAX_WIDTH  = bmc_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bmc_pkg::MAX_HEIGHT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  bmc_pix_if.sink                        in_pix,
  bmc_res_if.source                      out_res,
  input  logic                           cfg_we,
  input  logic [bmc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bmc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int QCW = $clog2(bmc_pkg::QUEUE_DEPTH + 1);
  localparam logic [XW-1:0] W_LAST_RST =
    XW'(((MAX_WIDTH < bmc_pkg::DIM_RESET) ? MAX_WIDTH : bmc_pkg::DIM_RESET) - 1);
  localparam logic [YW-1:0] H_LAST_RST =
    YW'(((MAX_HEIGHT < bmc_pkg::DIM_RESET) ? MAX_HEIGHT : bmc_pkg::DIM_RESET) - 1);

  // Configuration, held as the last column and row of the clamped frame.
  logic [XW-1:0]              w_last_r, w_last_nxt;
  logic [YW-1:0]              h_last_r, h_last_nxt;
  logic [bmc_pkg::MASK_W-1:0] mask_r, mask_nxt;
  logic                       restart;

  // Position of the next pixel.
  logic [XW-1:0] col_r, col_nxt;
  logic [YW-1:0] row_r, row_nxt;

  // Second stage: the word whose line-store data is being read.
  logic                      s1_valid_r;
  logic                      s1_emit_r;
  logic                      s1_end_r;
  logic [XW-1:0]             s1_col_r;
  logic [YW-1:0]             s1_row_r;
  logic [bmc_pkg::PIX_W-1:0] s1_px_r;

  logic                       in_acc;
  logic [QCW-1:0]             q_count;
  logic [bmc_pkg::LINE_W-1:0] ls_rd_data;
  logic [bmc_pkg::LINE_W-1:0] ls_wr_data;
  logic [bmc_pkg::WIN_ROWS-1:0][bmc_pkg::PIX_W-1:0] cur;
  logic [bmc_pkg::PIX_W-1:0]  win_sum;
  logic [YW-1:0]              row_m1;
  logic [XW-1:0]              col_m1;
  bmc_pkg::res_t              res;
  bmc_pkg::res_t              q_data;
  logic                       q_valid;

  assign in_pix.ready = ({1'b0, q_count} + (QCW+1)'(s1_valid_r))
                        < (QCW+1)'(bmc_pkg::QUEUE_DEPTH);
  assign in_acc       = in_pix.valid && in_pix.ready;

  always_comb begin
    w_last_nxt = w_last_r;
    h_last_nxt = h_last_r;
    mask_nxt   = mask_r;
    restart    = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index)
        bmc_pkg::CFG_IMAGE_WIDTH: begin
          w_last_nxt = XW'(bmc_pkg::dim_last(cfg_wdata, 32'(MAX_WIDTH)));
          restart    = 1'b1;
        end
        bmc_pkg::CFG_IMAGE_HEIGHT: begin
          h_last_nxt = YW'(bmc_pkg::dim_last(cfg_wdata, 32'(MAX_HEIGHT)));
          restart    = 1'b1;
        end
        bmc_pkg::CFG_KERNEL_MASK: begin
          mask_nxt = cfg_wdata[bmc_pkg::MASK_W-1:0];
          restart  = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (restart) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (in_acc) begin
      if (col_r == w_last_r) begin
        col_nxt = '0;
        row_nxt = (row_r == h_last_r) ? '0 : row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_last_r   <= W_LAST_RST;
      h_last_r   <= H_LAST_RST;
      mask_r     <= bmc_pkg::MASK_RESET;
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      w_last_r   <= w_last_nxt;
      h_last_r   <= h_last_nxt;
      mask_r     <= mask_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      s1_valid_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_px_r   <= in_pix.pixel;
      s1_col_r  <= col_r;
      s1_row_r  <= row_r;
      s1_emit_r <= (row_r >= YW'(2)) && (col_r >= XW'(2));
      s1_end_r  <= (row_r == h_last_r) && (col_r == w_last_r);
    end
  end

  // Each word is {row before last, last row}. Consecutive words never share a
  // column (a row is at least three wide), so the write-back of one word cannot
  // meet the read of the next.
  assign cur[0]     = ls_rd_data[bmc_pkg::LINE_W-1:bmc_pkg::PIX_W];
  assign cur[1]     = ls_rd_data[bmc_pkg::PIX_W-1:0];
  assign cur[2]     = s1_px_r;
  assign ls_wr_data = {cur[1], s1_px_r};

  bmc_line_store #(
    .DEPTH (MAX_WIDTH),
    .AW    (XW)
  ) u_line_store (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (col_r),
    .rd_data (ls_rd_data),
    .wr_en   (s1_valid_r),
    .wr_addr (s1_col_r),
    .wr_data (ls_wr_data)
  );

  bmc_window u_window (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (s1_valid_r),
    .cur   (cur),
    .mask  (mask_r),
    .sum   (win_sum)
  );

  assign row_m1 = s1_row_r - 1'b1;
  assign col_m1 = s1_col_r - 1'b1;

  always_comb begin
    res.out_row   = bmc_pkg::COORD_W'(row_m1);
    res.out_col   = bmc_pkg::COORD_W'(col_m1);
    res.value     = win_sum;
    res.frame_end = s1_end_r;
  end

  bmc_out_queue u_out_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s1_valid_r && s1_emit_r),
    .push_data (res),
    .pop_valid (q_valid),
    .pop_ready (out_res.ready),
    .pop_data  (q_data),
    .count     (q_count)
  );

  assign out_res.valid     = q_valid;
  assign out_res.out_row   = q_data.out_row;
  assign out_res.out_col   = q_data.out_col;
  assign out_res.value     = q_data.value;
  assign out_res.frame_end = q_data.frame_end;

endmodule

/* sv/bmc_checker.sv */
// Port-level checks for binary_mask_conv3x3_stream, attached by the bind below.
// Depends on bmc_pkg for field widths.
module bmc_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [bmc_pkg::COORD_W-1:0] out_row,
  input logic [bmc_pkg::COORD_W-1:0] out_col,
  input logic [bmc_pkg::PIX_W-1:0]   out_value,
  input logic                        out_frame_end
);

  // A result word offered but not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word withdrawn before it was taken");

  // A stalled result word keeps its contents.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_row) && $stable(out_col)
                                && $stable(out_value) && $stable(out_frame_end))
    else $error("stalled result word changed");

  // The queue starts empty after reset.
  a_empty_after_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result word offered straight after reset");

  // An empty output only fills with the result of an accepted pixel, carried through the second stage and the queue.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result word appeared without a matching pixel");

endmodule

bind binary_mask_conv3x3_stream bmc_checker u_bmc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_pix.valid),
  .in_ready      (in_pix.ready),
  .out_valid     (out_res.valid),
  .out_ready     (out_res.ready),
  .out_row       (out_res.out_row),
  .out_col       (out_res.out_col),
  .out_value     (out_res.value),
  .out_frame_end (out_res.frame_end)
);
